### sv/bbl_pkg.sv
package bbl_pkg;

  localparam int BYTE_W    = 48;
  localparam int OP_W      = 3;
  localparam int ST_W      = 3;
  localparam int TOTAL_W   = 7;
  localparam int STAT_W    = 32;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 64;

  localparam logic [BYTE_W-1:0]  BUDGET_RESET = 48'd268435456;
  localparam logic [PADDR_W-1:0] ADDR_MAX_RETAINED = 4'd0;

  typedef enum logic [OP_W-1:0] {
    OP_FIND  = 3'd0,
    OP_INS   = 3'd1,
    OP_ERASE = 3'd2,
    OP_CLEAR = 3'd3,
    OP_INVAL = 3'd4,
    OP_PIN   = 3'd5
  } op_t;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_ABSENT  = 3'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd2;
  localparam logic [ST_W-1:0] ST_FOREIGN = 3'd3;
  localparam logic [ST_W-1:0] ST_BUDGET  = 3'd4;
  localparam logic [ST_W-1:0] ST_PINNED  = 3'd5;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd6;

  // held > max, or add does not fit in what is left
  function automatic logic over_f(logic [BYTE_W-1:0] held, logic [BYTE_W-1:0] add,
                                  logic [BYTE_W-1:0] max);
    return (held > max) || (add > (max - held));
  endfunction

endpackage

### sv/bbl_ram.sv
module bbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/byte_budget_lru_cache_with_pinning.sv
// Channel  Ports                                  Handshake
// in       in_op .. in_pin_value                  in_valid / in_stall
// out      out_status .. out_insertion_count      out_valid / out_stall
// cfg      psel penable pwrite paddr pwdata       pready tied high, prdata
//
// Each item walks the entry RAM (one read port, one write port) one entry a
// cycle, and each pass visits every entry. Find, erase and set pin take one
// lookup pass plus at most one update pass; insert takes lookup, an optional
// drop pass, two passes per evicted entry, a rank pass and a place step.
// Clear, invalidate, unknown ops and early refusals go straight to finish.
// Reset clears valid and pinned flags at once; no clearing pass is needed.
// One item is in work at a time; a finished item waits in the output register
// and the next item is taken meanwhile.
module byte_budget_lru_cache_with_pinning
  import bbl_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64,
  parameter int ID_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [63:0]          in_lookup_key,
  input  logic [31:0]          in_image_id,
  input  logic [BYTE_W-1:0]    in_image_bytes,
  input  logic                 in_image_valid,
  input  logic                 in_image_on_device,
  input  logic                 in_pin_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ST_W-1:0]      out_status,
  output logic                 out_found,
  output logic [31:0]          out_found_image,
  output logic [BYTE_W-1:0]    out_retained_total,
  output logic [TOTAL_W-1:0]   out_entry_total,
  output logic [STAT_W-1:0]    out_epoch_now,
  output logic [STAT_W-1:0]    out_hit_count,
  output logic [STAT_W-1:0]    out_miss_count,
  output logic [STAT_W-1:0]    out_refusal_count,
  output logic [STAT_W-1:0]    out_eviction_count,
  output logic [STAT_W-1:0]    out_insertion_count,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = BYTE_W + IW;
  localparam int WW = KEY_BITS + ID_BITS + BYTE_W + IW;

  typedef enum logic [3:0] {
    S_IDLE, S_PASS, S_LDEC, S_EVL, S_VDEC, S_PLACE, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    P_LOOK, P_PROMO, P_DROP, P_VICT, P_BUMP
  } pmode_t;

  state_t state_r, ret_r;
  pmode_t pmode_r;

  logic [BYTE_W-1:0]   max_r;
  logic [ENTRIES-1:0]  valid_r, pinned_r;
  logic [CW-1:0]       cnt_r;
  logic [BYTE_W-1:0]   held_r;
  logic [STAT_W-1:0]   epoch_r, hit_cnt_r, miss_cnt_r, ref_cnt_r, ev_cnt_r, ins_cnt_r;

  logic [OP_W-1:0]     op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [ID_BITS-1:0]  img_r;
  logic [BYTE_W-1:0]   bytes_r;
  logic                pin_r;

  logic [IW:0]         rd_idx_r;
  logic                dv_r;
  logic [IW-1:0]       didx_r;

  logic                hit_r, ex_pin_r, anyunp_r;
  logic [IW-1:0]       ex_idx_r, ex_rank_r;
  logic [ID_BITS-1:0]  ex_img_r;
  logic [BYTE_W-1:0]   ex_size_r;
  logic [SW-1:0]       recl_r;
  logic                vic_hit_r;
  logic [IW-1:0]       vic_idx_r, vic_rank_r;
  logic [BYTE_W-1:0]   vic_size_r;
  logic                free_hit_r;
  logic [IW-1:0]       free_idx_r;
  logic [IW-1:0]       sel_idx_r, sel_rank_r;

  logic [ST_W-1:0]     res_st_r;
  logic                res_found_r;
  logic [31:0]         res_img_r;
  logic                out_valid_r;
  logic [ST_W-1:0]     o_st_r;
  logic                o_found_r;
  logic [31:0]         o_img_r;
  logic [BYTE_W-1:0]   o_held_r;
  logic [TOTAL_W-1:0]  o_cnt_r;
  logic [STAT_W-1:0]   o_epoch_r, o_hit_r, o_miss_r, o_ref_r, o_ev_r, o_ins_r;

  // RAM word: {key, image, size, rank}
  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [WW-1:0]       ram_wdata, rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [ID_BITS-1:0]  rd_img;
  logic [BYTE_W-1:0]   rd_size;
  logic [IW-1:0]       rd_rank, new_rank;
  logic                d_vld, d_pin, issue, pass_end;

  logic [BYTE_W-1:0]   cur;
  logic [BYTE_W:0]     need;
  logic [SW-1:0]       recl_eff;

  bbl_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign rd_key  = rdata[WW-1 -: KEY_BITS];
  assign rd_img  = rdata[IW+BYTE_W +: ID_BITS];
  assign rd_size = rdata[IW +: BYTE_W];
  assign rd_rank = rdata[IW-1:0];
  assign d_vld   = valid_r[didx_r];
  assign d_pin   = pinned_r[didx_r];

  assign issue     = (state_r == S_PASS) && (rd_idx_r < (IW+1)'(ENTRIES));
  assign ram_raddr = rd_idx_r[IW-1:0];
  assign pass_end  = dv_r && (didx_r == IW'(ENTRIES - 1));

  always_comb begin
    new_rank = rd_rank;
    case (pmode_r)
      P_PROMO: begin
        if (didx_r == sel_idx_r) begin
          new_rank = '0;
        end else if (rd_rank < sel_rank_r) begin
          new_rank = rd_rank + 1'b1;
        end
      end
      P_DROP: begin
        if (rd_rank > sel_rank_r) begin
          new_rank = rd_rank - 1'b1;
        end
      end
      P_BUMP:  new_rank = rd_rank + 1'b1;
      default: new_rank = rd_rank;
    endcase
  end

  always_comb begin
    if (state_r == S_PLACE) begin
      ram_we    = free_hit_r;
      ram_waddr = free_idx_r;
      ram_wdata = {key_r, img_r, bytes_r, IW'(0)};
    end else begin
      ram_we    = (state_r == S_PASS) && dv_r && d_vld &&
                  ((pmode_r == P_PROMO) || (pmode_r == P_DROP) || (pmode_r == P_BUMP));
      ram_waddr = didx_r;
      ram_wdata = {rdata[WW-1:IW], new_rank};
    end
  end

  // insert budget proof
  always_comb begin
    cur      = hit_r ? ((held_r >= ex_size_r) ? held_r - ex_size_r : '0) : held_r;
    need     = {1'b0, cur} + {1'b0, bytes_r} - {1'b0, max_r};
    recl_eff = recl_r - (hit_r ? SW'(ex_size_r) : SW'(0));
  end

  assign in_stall = (state_r != S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr == ADDR_MAX_RETAINED) ? PDATA_W'(max_r) : '0;

  assign out_valid           = out_valid_r;
  assign out_status          = o_st_r;
  assign out_found           = o_found_r;
  assign out_found_image     = o_img_r;
  assign out_retained_total  = o_held_r;
  assign out_entry_total     = o_cnt_r;
  assign out_epoch_now       = o_epoch_r;
  assign out_hit_count       = o_hit_r;
  assign out_miss_count      = o_miss_r;
  assign out_refusal_count   = o_ref_r;
  assign out_eviction_count  = o_ev_r;
  assign out_insertion_count = o_ins_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      pmode_r     <= P_LOOK;
      max_r       <= BUDGET_RESET;
      valid_r     <= '0;
      pinned_r    <= '0;
      cnt_r       <= '0;
      held_r      <= '0;
      epoch_r     <= STAT_W'(1);
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      ref_cnt_r   <= '0;
      ev_cnt_r    <= '0;
      ins_cnt_r   <= '0;
      rd_idx_r    <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr == ADDR_MAX_RETAINED)) begin
        max_r <= pwdata[BYTE_W-1:0];
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      dv_r   <= issue;
      didx_r <= rd_idx_r[IW-1:0];
      if (issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r        <= in_op;
            key_r       <= KEY_BITS'(in_lookup_key);
            img_r       <= ID_BITS'(in_image_id);
            bytes_r     <= in_image_bytes;
            pin_r       <= in_pin_value;
            res_st_r    <= ST_OK;
            res_found_r <= 1'b0;
            res_img_r   <= '0;
            hit_r       <= 1'b0;
            anyunp_r    <= 1'b0;
            recl_r      <= '0;
            rd_idx_r    <= '0;
            pmode_r     <= P_LOOK;
            ret_r       <= S_LDEC;
            state_r     <= S_PASS;
            case (in_op) inside
              OP_CLEAR, OP_INVAL: begin
                valid_r  <= '0;
                pinned_r <= '0;
                held_r   <= '0;
                cnt_r    <= '0;
                if (in_op == OP_INVAL) begin
                  epoch_r <= epoch_r + 1'b1;
                end
                state_r <= S_FINISH;
              end
              OP_FIND, OP_ERASE, OP_PIN: ;
              OP_INS: begin
                if (!in_image_valid) begin
                  res_st_r  <= ST_INVALID;
                  ref_cnt_r <= ref_cnt_r + 1'b1;
                  state_r   <= S_FINISH;
                end else if (!in_image_on_device) begin
                  res_st_r  <= ST_FOREIGN;
                  ref_cnt_r <= ref_cnt_r + 1'b1;
                  state_r   <= S_FINISH;
                end else if (in_image_bytes == '0) begin
                  res_st_r  <= ST_INVALID;
                  ref_cnt_r <= ref_cnt_r + 1'b1;
                  state_r   <= S_FINISH;
                end else if (in_image_bytes > max_r) begin
                  res_st_r  <= ST_BUDGET;
                  ref_cnt_r <= ref_cnt_r + 1'b1;
                  state_r   <= S_FINISH;
                end
              end
              default: begin
                res_st_r <= ST_INVALID;
                state_r  <= S_FINISH;
              end
            endcase
          end
        end

        S_PASS: begin
          if (dv_r) begin
            case (pmode_r)
              P_LOOK: begin
                if (d_vld && rd_key == key_r && !hit_r) begin
                  hit_r     <= 1'b1;
                  ex_idx_r  <= didx_r;
                  ex_rank_r <= rd_rank;
                  ex_img_r  <= rd_img;
                  ex_size_r <= rd_size;
                  ex_pin_r  <= d_pin;
                end
                if (d_vld && !d_pin) begin
                  recl_r   <= recl_r + SW'(rd_size);
                  anyunp_r <= 1'b1;
                end
              end
              P_VICT: begin
                if (d_vld && !d_pin && (!vic_hit_r || rd_rank > vic_rank_r)) begin
                  vic_hit_r  <= 1'b1;
                  vic_idx_r  <= didx_r;
                  vic_rank_r <= rd_rank;
                  vic_size_r <= rd_size;
                end
              end
              P_BUMP: begin
                if (!d_vld && !free_hit_r) begin
                  free_hit_r <= 1'b1;
                  free_idx_r <= didx_r;
                end
              end
              default: ;
            endcase
          end
          if (pass_end) begin
            state_r <= ret_r;
          end
        end

        S_LDEC: begin
          rd_idx_r <= '0;
          state_r  <= S_FINISH;
          case (op_r)
            OP_FIND: begin
              if (hit_r) begin
                hit_cnt_r   <= hit_cnt_r + 1'b1;
                res_found_r <= 1'b1;
                res_img_r   <= 32'(ex_img_r);
                sel_idx_r   <= ex_idx_r;
                sel_rank_r  <= ex_rank_r;
                pmode_r     <= P_PROMO;
                ret_r       <= S_FINISH;
                state_r     <= S_PASS;
              end else begin
                miss_cnt_r <= miss_cnt_r + 1'b1;
                res_st_r   <= ST_ABSENT;
              end
            end
            OP_ERASE: begin
              if (hit_r) begin
                res_found_r        <= 1'b1;
                valid_r[ex_idx_r]  <= 1'b0;
                pinned_r[ex_idx_r] <= 1'b0;
                held_r     <= (held_r >= ex_size_r) ? held_r - ex_size_r : '0;
                cnt_r      <= cnt_r - 1'b1;
                sel_rank_r <= ex_rank_r;
                pmode_r    <= P_DROP;
                ret_r      <= S_FINISH;
                state_r    <= S_PASS;
              end else begin
                res_st_r <= ST_ABSENT;
              end
            end
            OP_PIN: begin
              if (hit_r) begin
                res_found_r        <= 1'b1;
                pinned_r[ex_idx_r] <= pin_r;
              end else begin
                res_st_r <= ST_ABSENT;
              end
            end
            default: begin
              // insert
              if (hit_r && ex_img_r == img_r) begin
                sel_idx_r  <= ex_idx_r;
                sel_rank_r <= ex_rank_r;
                pmode_r    <= P_PROMO;
                ret_r      <= S_FINISH;
                state_r    <= S_PASS;
              end else if (hit_r && ex_pin_r) begin
                res_st_r  <= ST_PINNED;
                ref_cnt_r <= ref_cnt_r + 1'b1;
              end else if (over_f(cur, bytes_r, max_r) && (recl_eff < SW'(need))) begin
                res_st_r  <= ST_BUDGET;
                ref_cnt_r <= ref_cnt_r + 1'b1;
              end else if (!over_f(cur, bytes_r, max_r) && !hit_r &&
                           cnt_r >= CW'(ENTRIES) && !anyunp_r) begin
                res_st_r  <= ST_FULL;
                ref_cnt_r <= ref_cnt_r + 1'b1;
              end else if (hit_r) begin
                // drop the replaced entry, not an eviction
                valid_r[ex_idx_r]  <= 1'b0;
                pinned_r[ex_idx_r] <= 1'b0;
                held_r     <= (held_r >= ex_size_r) ? held_r - ex_size_r : '0;
                cnt_r      <= cnt_r - 1'b1;
                sel_rank_r <= ex_rank_r;
                pmode_r    <= P_DROP;
                ret_r      <= S_EVL;
                state_r    <= S_PASS;
              end else begin
                state_r <= S_EVL;
              end
            end
          endcase
        end

        S_EVL: begin
          rd_idx_r <= '0;
          state_r  <= S_PASS;
          if (over_f(held_r, bytes_r, max_r) || cnt_r >= CW'(ENTRIES)) begin
            vic_hit_r <= 1'b0;
            pmode_r   <= P_VICT;
            ret_r     <= S_VDEC;
          end else begin
            free_hit_r <= 1'b0;
            pmode_r    <= P_BUMP;
            ret_r      <= S_PLACE;
          end
        end

        S_VDEC: begin
          if (!vic_hit_r) begin
            res_st_r  <= over_f(held_r, bytes_r, max_r) ? ST_BUDGET : ST_FULL;
            ref_cnt_r <= ref_cnt_r + 1'b1;
            state_r   <= S_FINISH;
          end else begin
            valid_r[vic_idx_r]  <= 1'b0;
            pinned_r[vic_idx_r] <= 1'b0;
            held_r     <= (held_r >= vic_size_r) ? held_r - vic_size_r : '0;
            cnt_r      <= cnt_r - 1'b1;
            ev_cnt_r   <= ev_cnt_r + 1'b1;
            sel_rank_r <= vic_rank_r;
            rd_idx_r   <= '0;
            pmode_r    <= P_DROP;
            ret_r      <= S_EVL;
            state_r    <= S_PASS;
          end
        end

        S_PLACE: begin
          if (free_hit_r) begin
            valid_r[free_idx_r]  <= 1'b1;
            pinned_r[free_idx_r] <= 1'b0;
            held_r    <= held_r + bytes_r;
            cnt_r     <= cnt_r + 1'b1;
            ins_cnt_r <= ins_cnt_r + 1'b1;
          end else begin
            res_st_r  <= ST_FULL;
            ref_cnt_r <= ref_cnt_r + 1'b1;
          end
          state_r <= S_FINISH;
        end

        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            o_st_r      <= res_st_r;
            o_found_r   <= res_found_r;
            o_img_r     <= res_img_r;
            o_held_r    <= held_r;
            o_cnt_r     <= TOTAL_W'(cnt_r);
            o_epoch_r   <= epoch_r;
            o_hit_r     <= hit_cnt_r;
            o_miss_r    <= miss_cnt_r;
            o_ref_r     <= ref_cnt_r;
            o_ev_r      <= ev_cnt_r;
            o_ins_r     <= ins_cnt_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CW'($countones(valid_r)))
    else $error("entry count differs from valid flags");

  a_pin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pinned_r & ~valid_r) == '0)
    else $error("pinned flag on an empty slot");

  a_place_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |-> (!over_f(held_r, bytes_r, max_r) && cnt_r < CW'(ENTRIES)))
    else $error("placing an entry without room");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("finished item not presented");

endmodule
